// File: rtl/lmsd_pkg.sv
package lmsd_pkg;

  localparam int unsigned FrameCols = 14;
  localparam int unsigned FrameRows = 5;
  localparam int unsigned EyeCols   = 7;
  localparam int unsigned GlyphCols = 3;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned MemW      = 2 * FrameRows;
  localparam int unsigned DriveW    = 12;
  localparam int unsigned WordW     = 2 * DriveW;

  localparam logic [DriveW-1:0] RightBase = 12'b1111_1101_0000;
  localparam logic [DriveW-1:0] LeftBase  = 12'b0000_0111_1111;

  typedef enum logic [2:0] {
    FUNC_SET_PIXEL   = 3'd0,
    FUNC_CLEAR_PIXEL = 3'd1,
    FUNC_CLEAR_FRAME = 3'd2,
    FUNC_WRITE_GLYPH = 3'd3,
    FUNC_SCAN_FRAME  = 3'd4
  } func_e;

  typedef struct packed {
    logic load;
    logic clr_frame;
    logic rmw_wr;
    logic k_next;
    logic scan_start;
    logic scan_run;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic is_pixel;
    logic is_clear;
    logic is_glyph;
    logic is_scan;
    logic tgt_ok;
    logic glyph_done;
    logic blocked;
    logic scan_end;
    logic flush_done;
  } sts_t;

  function automatic logic [3:0] right_col_bit(logic [2:0] c);
    logic [3:0] b;
    case (c)
      3'd0:    b = 4'd8;
      3'd1:    b = 4'd7;
      3'd2:    b = 4'd4;
      3'd3:    b = 4'd6;
      3'd4:    b = 4'd9;
      3'd5:    b = 4'd10;
      default: b = 4'd11;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] right_row_bit(logic [2:0] r);
    logic [3:0] b;
    case (r)
      3'd0:    b = 4'd0;
      3'd1:    b = 4'd3;
      3'd2:    b = 4'd1;
      3'd3:    b = 4'd2;
      default: b = 4'd5;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] left_row_bit(logic [2:0] r);
    logic [3:0] b;
    case (r)
      3'd0:    b = 4'd8;
      3'd1:    b = 4'd9;
      3'd2:    b = 4'd10;
      3'd3:    b = 4'd11;
      default: b = 4'd7;
    endcase
    return b;
  endfunction

  function automatic logic [DriveW-1:0] right_drive(logic [2:0] c, logic [2:0] r);
    logic [DriveW-1:0] d;
    d = RightBase;
    d[right_col_bit(c)] = 1'b0;
    d[right_row_bit(r)] = 1'b1;
    return d;
  endfunction

  function automatic logic [DriveW-1:0] left_drive(logic [2:0] c, logic [2:0] r);
    logic [DriveW-1:0] d;
    d = LeftBase;
    d[{1'b0, c}] = 1'b0;
    d[left_row_bit(r)] = 1'b1;
    return d;
  endfunction

  function automatic logic [FrameRows-1:0] glyph_col(logic g, logic [1:0] k);
    logic [FrameRows-1:0] v;
    case ({g, k})
      3'b000:  v = 5'b11110;
      3'b001:  v = 5'b00101;
      3'b010:  v = 5'b11110;
      3'b100:  v = 5'b11111;
      3'b101:  v = 5'b10101;
      3'b110:  v = 5'b01010;
      default: v = 5'b00000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/lmsd_ram.sv
module lmsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lmsd_ctrl.sv
module lmsd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lmsd_pkg::sts_t  sts_i,
  output lmsd_pkg::cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_RD    = 6'b000100,
    S_WR    = 6'b001000,
    S_SCAN  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.is_clear) begin
          cmd_o.clr_frame = 1'b1;
          state_d         = S_IDLE;
        end else if ((sts_i.is_pixel || sts_i.is_glyph) && sts_i.tgt_ok) begin
          state_d = S_WR;
        end else if (sts_i.is_scan) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        if (sts_i.tgt_ok) begin
          state_d = S_WR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WR: begin
        cmd_o.rmw_wr = 1'b1;
        if (sts_i.glyph_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.k_next = 1'b1;
          state_d      = S_RD;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (!sts_i.blocked && sts_i.scan_end) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (sts_i.flush_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// File: rtl/lmsd_datapath.sv
module lmsd_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [2:0]                         func_i,
  input  logic [3:0]                         col_i,
  input  logic [2:0]                         row_i,
  input  logic                               glyph_i,
  input  lmsd_pkg::cmd_t                     cmd_i,
  output lmsd_pkg::sts_t                     sts_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lmsd_pkg::WordW-1:0]         drive_word_o,
  output logic                               last_o
);

  logic [2:0] func_q;
  logic [3:0] col_q;
  logic [2:0] row_q;
  logic       glyph_q;
  logic [1:0] k_q;

  logic [lmsd_pkg::EyeCols-1:0] vld_q;
  logic                         rd_vld_q;

  logic [lmsd_pkg::AddrW-1:0] ram_addr;
  logic                       ram_we;
  logic [lmsd_pkg::MemW-1:0]  ram_wdata;
  logic [lmsd_pkg::MemW-1:0]  ram_rdata;
  logic [lmsd_pkg::MemW-1:0]  old_word;

  logic [4:0]                     tgt_col;
  logic                           left_half;
  logic [lmsd_pkg::AddrW-1:0]     tgt_addr;
  logic [lmsd_pkg::FrameRows-1:0] old_col;
  logic [lmsd_pkg::FrameRows-1:0] new_col;
  logic [lmsd_pkg::FrameRows-1:0] pix_mask;
  logic                           is_pixel;
  logic                           is_glyph;

  logic [2:0]                     r1_q;
  logic [2:0]                     c1_q;
  logic [2:0]                     next_c;
  logic [lmsd_pkg::FrameRows-1:0] scan_mask;
  logic                           rhit;
  logic                           lhit;
  logic                           hit;
  logic [lmsd_pkg::WordW-1:0]     scan_word;
  logic                           advance;

  logic                       pend_valid_q;
  logic [lmsd_pkg::WordW-1:0] pend_word_q;
  logic                       out_free;
  logic                       push;
  logic                       push_last;

  logic                       out_valid_q;
  logic [lmsd_pkg::WordW-1:0] out_word_q;
  logic                       out_last_q;

  assign is_pixel = (func_q == lmsd_pkg::FUNC_SET_PIXEL) ||
                    (func_q == lmsd_pkg::FUNC_CLEAR_PIXEL);
  assign is_glyph = (func_q == lmsd_pkg::FUNC_WRITE_GLYPH);

  assign tgt_col   = {1'b0, col_q} + {3'b000, k_q};
  assign left_half = (tgt_col >= 5'(lmsd_pkg::EyeCols));
  assign tgt_addr  = left_half ? 3'(tgt_col - 5'(lmsd_pkg::EyeCols)) : tgt_col[2:0];

  assign old_word = rd_vld_q ? ram_rdata : '0;
  assign old_col  = left_half ? old_word[9:5] : old_word[4:0];
  assign pix_mask = 5'd1 << row_q;

  always_comb begin
    case (func_q)
      lmsd_pkg::FUNC_SET_PIXEL:   new_col = old_col | pix_mask;
      lmsd_pkg::FUNC_CLEAR_PIXEL: new_col = old_col & ~pix_mask;
      lmsd_pkg::FUNC_WRITE_GLYPH: new_col = lmsd_pkg::glyph_col(glyph_q, k_q);
      default:                    new_col = old_col;
    endcase
  end

  assign ram_wdata = left_half ? {new_col, old_word[4:0]} : {old_word[9:5], new_col};
  assign ram_we    = cmd_i.rmw_wr;

  assign next_c    = (c1_q == 3'(lmsd_pkg::EyeCols - 1)) ? 3'd0 : c1_q + 3'd1;
  assign scan_mask = 5'd1 << r1_q;
  assign rhit      = |(old_word[4:0] & scan_mask);
  assign lhit      = |(old_word[9:5] & scan_mask);
  assign hit       = rhit || lhit;
  assign scan_word = {rhit ? lmsd_pkg::right_drive(c1_q, r1_q) : 12'd0,
                      lhit ? lmsd_pkg::left_drive(c1_q, r1_q) : 12'd0};

  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = cmd_i.scan_run && !(hit && pend_valid_q && !out_free);

  always_comb begin
    ram_addr = tgt_addr;
    if (cmd_i.scan_start) begin
      ram_addr = '0;
    end else if (cmd_i.scan_run) begin
      ram_addr = advance ? next_c : c1_q;
    end
  end

  assign push      = (advance && hit && pend_valid_q) ||
                     (cmd_i.flush && pend_valid_q && out_free);
  assign push_last = cmd_i.flush;

  lmsd_ram #(
    .Width (lmsd_pkg::MemW),
    .Depth (lmsd_pkg::EyeCols)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    rd_vld_q <= vld_q[ram_addr];
    if (cmd_i.load) begin
      func_q  <= func_i;
      col_q   <= col_i;
      row_q   <= row_i;
      glyph_q <= glyph_i;
      k_q     <= 2'd0;
    end else if (cmd_i.k_next) begin
      k_q <= k_q + 2'd1;
    end
    if (cmd_i.scan_start) begin
      r1_q <= 3'd0;
      c1_q <= 3'd0;
    end else if (advance) begin
      c1_q <= next_c;
      if (c1_q == 3'(lmsd_pkg::EyeCols - 1)) begin
        r1_q <= r1_q + 3'd1;
      end
    end
    if (advance && hit) begin
      pend_word_q <= scan_word;
    end
    if (push) begin
      out_word_q <= pend_word_q;
      out_last_q <= push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_frame) begin
        vld_q <= '0;
      end else if (ram_we) begin
        vld_q[tgt_addr] <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        pend_valid_q <= 1'b0;
      end else if (advance && hit) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush && out_free) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.is_pixel   = is_pixel;
  assign sts_o.is_clear   = (func_q == lmsd_pkg::FUNC_CLEAR_FRAME);
  assign sts_o.is_glyph   = is_glyph;
  assign sts_o.is_scan    = (func_q == lmsd_pkg::FUNC_SCAN_FRAME);
  assign sts_o.tgt_ok     = (tgt_col < 5'(lmsd_pkg::FrameCols)) &&
                            (is_glyph || (row_q < 3'(lmsd_pkg::FrameRows)));
  assign sts_o.glyph_done = !is_glyph || (k_q == 2'(lmsd_pkg::GlyphCols - 1));
  assign sts_o.blocked    = !advance;
  assign sts_o.scan_end   = (r1_q == 3'(lmsd_pkg::FrameRows - 1)) &&
                            (c1_q == 3'(lmsd_pkg::EyeCols - 1));
  assign sts_o.flush_done = !pend_valid_q || out_free;

  assign out_valid_o  = out_valid_q;
  assign drive_word_o = out_word_q;
  assign last_o       = out_last_q;

endmodule

// File: rtl/led_matrix_scan_driver.sv
// Frame buffer and scan driver for two 7x5 LED eyes (14 columns by 5 rows).
// Input channel: in_valid_i / in_stall_o carry one command word made of
// func_i, col_i, row_i and glyph_i. Output channel: out_valid_o / out_stall_i
// carry drive_word_o (left drive in 11:0, right drive in 23:12) and last_o.
// A word moves on a clock edge with valid high and stall low.
// Commands run one at a time; in_stall_o is high while one is in progress.
// Set and clear pixel read and rewrite one frame RAM entry; a glyph write
// does one read-modify-write of the 7-entry frame RAM per column. A scan
// walks the 35 row-column positions, one per cycle through the frame RAM
// read port unless a stall holds it; each lit position yields one drive
// word, held back one word so the final one can carry last_o. The output
// register lets a new command enter while the last drive word still waits.
// When the receiver stalls, the scan pauses at the next lit position and
// resumes as soon as the output register drains.
// Reset clears the frame (per-entry valid bits) and the control state; no
// clearing pass is needed and the block accepts a command straight out of reset.
module led_matrix_scan_driver (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 func_i,
  input  logic [3:0]                 col_i,
  input  logic [2:0]                 row_i,
  input  logic                       glyph_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [lmsd_pkg::WordW-1:0] drive_word_o,
  output logic                       last_o
);

  lmsd_pkg::cmd_t cmd;
  lmsd_pkg::sts_t sts;

  lmsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lmsd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .glyph_i      (glyph_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drive_word_o (drive_word_o),
    .last_o       (last_o)
  );

endmodule
